@@ rtl/core/hstwm_pkg.sv @@
// ----------------------------------------------------------------------------
// hstwm_pkg: shared types and codes for the two-wire sensor bus master
// Request codes and data pin drive modes used by the bus master.
// ----------------------------------------------------------------------------
package hstwm_pkg;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_CONN_RESET = 2'd1,
    REQ_SEND_BYTE = 2'd2,
    REQ_READ_WORD = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    DM_LOW = 2'd0,
    DM_HIGH = 2'd1,
    DM_REL = 2'd2
  } data_mode_t;

  // Encoding that no drive mode uses.
  localparam logic [1:0] DM_UNUSED = 2'd3;

  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned WORD_BITS = 16;

endpackage

@@ rtl/core/humidity_sensor_two_wire_master.sv @@
// ----------------------------------------------------------------------------
// humidity_sensor_two_wire_master: bus master for a two-wire humidity sensor
// Steps one quarter clock period per input tick and emits pin levels and status.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  input   | in_valid/in_ready  | req_valid, req_type, tx_byte, data_line
//  output  | out_valid/out_ready| clock_level, data_mode, busy_res, done_res,
//          |                    | ack_bit, read_word
//
// One tick is processed per clock cycle; its result appears in the output
// register on the next cycle. The phase logic between the sequencer state and
// the output register is the whole path, so ticks may arrive back to back.
// The input is stalled only while the output register holds an untaken result.
// Reset returns the sequencer to idle with clock low and data released.

module humidity_sensor_two_wire_master #(
  parameter int unsigned RESET_PULSES = 9
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_valid,
  input  logic [1:0]  req_type,
  input  logic [7:0]  tx_byte,
  input  logic        data_line,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        clock_level,
  output logic [1:0]  data_mode,
  output logic        busy_res,
  output logic        done_res,
  output logic        ack_bit,
  output logic [15:0] read_word
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST0, PH_ST1, PH_ST2, PH_ST3, PH_ST4, PH_ST5,
    PH_RS0, PH_RS1, PH_RS2,
    PH_TX0, PH_TX1, PH_TX2, PH_TX3,
    PH_RWAIT, PH_RLO, PH_RHIA, PH_RHIB,
    PH_ALO, PH_AHI, PH_FLO, PH_FHI
  } phase_t;

  localparam logic [3:0] PULSE_LIMIT = 4'(RESET_PULSES);

  phase_t                 phase, phase_next;
  logic [1:0]             tick, tick_next;
  logic [4:0]             bit_cnt, bit_cnt_next;
  logic [3:0]             pulse, pulse_next;
  logic [15:0]            shift, shift_next;
  logic                   ack, ack_next;
  logic                   pin_clk, pin_clk_next;
  hstwm_pkg::data_mode_t  pin_dm, pin_dm_next;
  logic [7:0]             tx_latch, tx_latch_next;

  logic                   cur_clk;
  hstwm_pkg::data_mode_t  cur_dm;
  logic                   cur_busy, cur_done;

  phase_t                 p;
  logic                   len_one, adv;
  logic [4:0]             bit_inc;
  logic [3:0]             pulse_inc;
  logic [3:0]             rd_idx;

  logic                   in_fire;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    phase_next    = phase;
    tick_next     = tick;
    bit_cnt_next  = bit_cnt;
    pulse_next    = pulse;
    shift_next    = shift;
    ack_next      = ack;
    pin_clk_next  = pin_clk;
    pin_dm_next   = pin_dm;
    tx_latch_next = tx_latch;
    cur_clk       = 1'b0;
    cur_dm        = hstwm_pkg::DM_REL;
    cur_busy      = 1'b0;
    cur_done      = 1'b0;
    len_one       = 1'b0;
    adv           = 1'b0;
    rd_idx        = 4'd15 - bit_cnt[3:0];

    // A request on an idle tick starts its sequence on that same tick.
    p = phase;
    if (phase == PH_IDLE && req_valid) begin
      tick_next    = 2'd0;
      bit_cnt_next = 5'd0;
      pulse_next   = 4'd0;
      case (hstwm_pkg::req_type_t'(req_type))
        hstwm_pkg::REQ_START:      p = PH_ST0;
        hstwm_pkg::REQ_CONN_RESET: p = PH_RS0;
        hstwm_pkg::REQ_SEND_BYTE: begin
          p = PH_TX0;
          tx_latch_next = tx_byte;
        end
        default: begin
          p = PH_RWAIT;
          shift_next = '0;
        end
      endcase
    end
    phase_next = p;
    bit_inc    = bit_cnt_next + 5'd1;
    pulse_inc  = pulse_next + 4'd1;

    if (p == PH_IDLE) begin
      cur_clk = pin_clk;
      cur_dm  = pin_dm;
    end else begin
      cur_busy = 1'b1;
      unique case (p)
        PH_ST0:   begin cur_clk = 1'b0; cur_dm = hstwm_pkg::DM_HIGH; end
        PH_ST1:   begin cur_clk = 1'b1; cur_dm = hstwm_pkg::DM_HIGH; len_one = 1'b1; end
        PH_ST2:   begin cur_clk = 1'b1; cur_dm = hstwm_pkg::DM_LOW;  len_one = 1'b1; end
        PH_ST3:   begin cur_clk = 1'b0; cur_dm = hstwm_pkg::DM_LOW; end
        PH_ST4:   begin cur_clk = 1'b1; cur_dm = hstwm_pkg::DM_LOW;  len_one = 1'b1; end
        PH_ST5:   begin cur_clk = 1'b1; cur_dm = hstwm_pkg::DM_HIGH; len_one = 1'b1; end
        PH_RS0:   begin cur_clk = 1'b0; cur_dm = hstwm_pkg::DM_HIGH; end
        PH_RS1:   begin cur_clk = 1'b1; cur_dm = hstwm_pkg::DM_HIGH; end
        PH_RS2:   begin cur_clk = 1'b0; cur_dm = hstwm_pkg::DM_HIGH; end
        PH_TX0, PH_TX1: begin
          cur_clk = (p == PH_TX1);
          cur_dm  = tx_latch_next[3'd7 - bit_cnt_next[2:0]] ?
                    hstwm_pkg::DM_HIGH : hstwm_pkg::DM_LOW;
        end
        PH_TX2:   cur_clk = 1'b0;
        PH_TX3: begin
          cur_clk = 1'b1;
          if (tick_next == 2'd0) begin
            ack_next = data_line;
          end
        end
        PH_RWAIT: begin cur_clk = 1'b0; len_one = 1'b1; end
        PH_RLO:   cur_clk = 1'b0;
        PH_RHIA:  begin cur_clk = 1'b1; len_one = 1'b1; end
        PH_RHIB:  begin cur_clk = 1'b1; len_one = 1'b1; end
        PH_ALO:   begin cur_clk = 1'b0; cur_dm = hstwm_pkg::DM_LOW; end
        PH_AHI:   begin cur_clk = 1'b1; cur_dm = hstwm_pkg::DM_LOW; end
        PH_FLO:   cur_clk = 1'b0;
        default:  cur_clk = 1'b1;
      endcase
      pin_clk_next = cur_clk;
      pin_dm_next  = cur_dm;

      adv = len_one || (tick_next != 2'd0);
      if (!adv) begin
        tick_next = tick_next + 2'd1;
      end else begin
        tick_next = 2'd0;
        unique case (p)
          PH_ST5, PH_TX3, PH_FHI: begin
            phase_next   = PH_IDLE;
            cur_done     = 1'b1;
            pin_clk_next = 1'b0;
            pin_dm_next  = (p == PH_ST5) ? hstwm_pkg::DM_HIGH : hstwm_pkg::DM_REL;
          end
          PH_RS2: begin
            pulse_next = pulse_inc;
            phase_next = (pulse_inc >= PULSE_LIMIT) ? PH_ST0 : PH_RS1;
          end
          PH_TX1: begin
            bit_cnt_next = bit_inc;
            phase_next   = (bit_inc >= 5'(hstwm_pkg::BYTE_BITS)) ? PH_TX2 : PH_TX0;
          end
          PH_RWAIT: begin
            if (!data_line) begin
              phase_next = PH_RLO;
            end
          end
          PH_RHIB: begin
            // Sample in the middle of the high clock phase, MSB first.
            shift_next[rd_idx] = data_line;
            bit_cnt_next = bit_inc;
            if (bit_inc == 5'(hstwm_pkg::BYTE_BITS)) begin
              phase_next = PH_ALO;
            end else if (bit_inc >= 5'(hstwm_pkg::WORD_BITS)) begin
              phase_next = PH_FLO;
            end else begin
              phase_next = PH_RLO;
            end
          end
          PH_AHI:  phase_next = PH_RLO;
          default: phase_next = phase_t'(p + 5'd1);
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      tick      <= 2'd0;
      bit_cnt   <= 5'd0;
      pulse     <= 4'd0;
      shift     <= '0;
      ack       <= 1'b0;
      pin_clk   <= 1'b0;
      pin_dm    <= hstwm_pkg::DM_REL;
      tx_latch  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        phase    <= phase_next;
        tick     <= tick_next;
        bit_cnt  <= bit_cnt_next;
        pulse    <= pulse_next;
        shift    <= shift_next;
        ack      <= ack_next;
        pin_clk  <= pin_clk_next;
        pin_dm   <= pin_dm_next;
        tx_latch <= tx_latch_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      clock_level <= cur_clk;
      data_mode   <= cur_dm;
      busy_res    <= cur_busy;
      done_res    <= cur_done;
      ack_bit     <= ack_next;
      read_word   <= shift_next;
    end
  end

  // A sequence always ends on a tick with the clock high.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> busy_res && clock_level)
    else $error("done without busy or with clock low");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> data_mode != hstwm_pkg::DM_UNUSED)
    else $error("undefined data pin mode");

  assert property (@(posedge clk) disable iff (rst)
    in_fire && phase == PH_IDLE && !req_valid |=> !busy_res && !done_res)
    else $error("idle tick reported as busy");

  assert property (@(posedge clk) disable iff (rst)
    in_fire && phase == PH_IDLE && req_valid |=> busy_res && !done_res)
    else $error("accepted request did not start a sequence");

  assert property (@(posedge clk) disable iff (rst)
    in_fire && phase == PH_IDLE |=> clock_level == $past(pin_clk) || busy_res)
    else $error("idle tick changed the clock level");

endmodule
